### sv/its_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// its_pkg: shared types and constants for the integer text scanner
// Item payloads, configuration struct, register map and field sizes.
// ----------------------------------------------------------------------------
package its_pkg;

  localparam int unsigned MAX_FIELD_WIDTH = 128;
  localparam int unsigned VALUE_BITS      = 32;
  localparam int unsigned CNT_W           = 8;
  localparam int unsigned ACC_W           = VALUE_BITS + 5;
  localparam int unsigned PADDR_W         = 4;
  localparam int unsigned PDATA_W         = 32;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_BASE_MODE   = 2'd0;
  localparam logic [1:0] REG_SIGNED_MODE = 2'd1;
  localparam logic [1:0] REG_FIELD_WIDTH = 2'd2;

  // base codes
  localparam logic [1:0] BASE_AUTO = 2'd0;
  localparam logic [1:0] BASE_OCT  = 2'd1;
  localparam logic [1:0] BASE_DEC  = 2'd2;
  localparam logic [1:0] BASE_HEX  = 2'd3;

  typedef logic [ACC_W-1:0]      acc_t;
  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } its_in_t;

  typedef struct packed {
    logic       consumed;
    logic       done_res;
    val_t       value;
    cnt_t       char_count;
    logic       saturated;
  } its_out_t;

  typedef struct packed {
    logic [1:0] base_mode;
    logic       signed_mode;
    logic [7:0] field_width;
  } its_cfg_t;

  // field restart request from a configuration write
  typedef struct packed {
    logic       restart;
    logic [1:0] base;
  } its_rst_t;

endpackage

`default_nettype wire

### sv/its_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// its_cfg: configuration registers
// APB-style register file with base mode, sign mode and field width.
// ----------------------------------------------------------------------------
module its_cfg import its_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output      logic [PDATA_W-1:0] prdata,
  output      logic               pready,
  output      its_cfg_t           cfg_o,
  output      its_rst_t           rst_req_o
);

  its_cfg_t   cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    rst_req_o.restart = 1'b0;
    if (wr_en) begin
      unique case (reg_idx)
        REG_BASE_MODE: begin
          cfg_d.base_mode   = pwdata[1:0];
          rst_req_o.restart = 1'b1;
        end
        REG_SIGNED_MODE: begin
          cfg_d.signed_mode = pwdata[0];
          rst_req_o.restart = 1'b1;
        end
        REG_FIELD_WIDTH: begin
          cfg_d.field_width = pwdata[7:0];
          rst_req_o.restart = 1'b1;
        end
        default: ;
      endcase
    end
    rst_req_o.base = cfg_d.base_mode;
  end

  always_comb begin
    unique case (reg_idx)
      REG_BASE_MODE:   prdata = PDATA_W'(cfg_q.base_mode);
      REG_SIGNED_MODE: prdata = PDATA_W'(cfg_q.signed_mode);
      REG_FIELD_WIDTH: prdata = PDATA_W'(cfg_q.field_width);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_mode   <= BASE_DEC;
      cfg_q.signed_mode <= 1'b1;
      cfg_q.field_width <= CNT_W'(MAX_FIELD_WIDTH);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### sv/its_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// its_scan: field scanner
// Holds the field state and, for one character per cycle when step_i
// is high, decides whether it is consumed, accumulates the digit and forms the final value.
// ----------------------------------------------------------------------------
module its_scan import its_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,
  input  wire its_in_t  item_i,
  input  wire its_cfg_t cfg_i,
  input  wire its_rst_t rst_req_i,
  output      its_out_t res_o
);

  typedef enum logic [3:0] {
    PH_AUTO_START, PH_AUTO_SIGNED, PH_AUTO_ZERO, PH_PLAIN_START,
    PH_PLAIN_SIGNED, PH_DIGITS, PH_HEX_START, PH_HEX_SIGNED, PH_HEX_ZERO
  } phase_e;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CH_UC_X  = 8'h58;

  phase_e     ph_q, ph_d, ph_start;
  logic [1:0] base_q, base_d;
  logic       neg_q, neg_d;
  val_t       mag_q, mag_d;
  logic       ovf_q, ovf_d;
  cnt_t       cnt_q, cnt_d;

  logic [7:0] ch;
  logic [5:0] dig;
  logic       is_alnum;
  logic       took, acc_en, done;
  logic [5:0] radix;
  acc_t       prod, sum;
  cnt_t       limit;
  val_t       fval;
  logic       sat;
  logic [1:0] new_base;

  assign ch = item_i.char_code;

  always_comb begin
    dig      = 6'd0;
    is_alnum = 1'b1;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      dig = 6'(ch - CH_ZERO);
    end else if (ch >= CH_LC_A && ch <= CH_LC_Z) begin
      dig = 6'(ch - CH_LC_A) + 6'd10;
    end else if (ch >= CH_UC_A && ch <= CH_UC_Z) begin
      dig = 6'(ch - CH_UC_A) + 6'd10;
    end else begin
      is_alnum = 1'b0;
    end
  end

  always_comb begin
    if (cfg_i.field_width == 8'd0) begin
      limit = cnt_t'(1);
    end else if (cfg_i.field_width > CNT_W'(MAX_FIELD_WIDTH)) begin
      limit = cnt_t'(MAX_FIELD_WIDTH);
    end else begin
      limit = cfg_i.field_width;
    end
  end

  // character decision
  always_comb begin
    took   = 1'b0;
    acc_en = 1'b0;
    ph_d   = ph_q;
    base_d = base_q;
    neg_d  = neg_q;
    if (ch == CH_PLUS || ch == CH_MINUS) begin
      unique case (ph_q)
        PH_AUTO_START:  begin took = 1'b1; ph_d = PH_AUTO_SIGNED;  end
        PH_PLAIN_START: begin took = 1'b1; ph_d = PH_PLAIN_SIGNED; end
        PH_HEX_START:   begin took = 1'b1; ph_d = PH_HEX_SIGNED;   end
        default: ;
      endcase
      if (took) neg_d = (ch == CH_MINUS);
    end else if (ch == CH_ZERO) begin
      took = 1'b1;
      unique case (ph_q)
        PH_AUTO_START, PH_AUTO_SIGNED: ph_d = PH_AUTO_ZERO;
        PH_AUTO_ZERO: begin
          base_d = BASE_OCT;
          ph_d   = PH_DIGITS;
        end
        PH_HEX_START, PH_HEX_SIGNED: ph_d = PH_HEX_ZERO;
        default: begin
          ph_d   = PH_DIGITS;
          acc_en = 1'b1;
        end
      endcase
    end else if (ch == CH_LC_X || ch == CH_UC_X) begin
      if (ph_q == PH_AUTO_ZERO) begin
        took   = 1'b1;
        base_d = BASE_HEX;
        ph_d   = PH_DIGITS;
      end else if (ph_q == PH_HEX_ZERO) begin
        took = 1'b1;
        ph_d = PH_DIGITS;
      end
    end else if (is_alnum) begin
      unique case (ph_q)
        PH_AUTO_START, PH_AUTO_SIGNED: begin
          if (dig >= 6'd1 && dig <= 6'd9) begin
            took   = 1'b1;
            base_d = BASE_DEC;
          end
        end
        PH_AUTO_ZERO: begin
          if (dig >= 6'd1 && dig <= 6'd7) begin
            took   = 1'b1;
            base_d = BASE_OCT;
          end
        end
        default: begin
          unique case (base_q)
            BASE_OCT: took = (dig < 6'd8);
            BASE_HEX: took = (dig < 6'd16);
            default:  took = (dig < 6'd10);
          endcase
        end
      endcase
      if (took) begin
        ph_d   = PH_DIGITS;
        acc_en = 1'b1;
      end
    end
  end

  // multiply-add by shifts, overflow when the sum leaves the value width
  always_comb begin
    unique case (base_d)
      BASE_OCT: begin
        radix = 6'd8;
        prod  = acc_t'(mag_q) << 3;
      end
      BASE_HEX: begin
        radix = 6'd16;
        prod  = acc_t'(mag_q) << 4;
      end
      default: begin
        radix = 6'd10;
        prod  = (acc_t'(mag_q) << 3) + (acc_t'(mag_q) << 1);
      end
    endcase
    sum   = prod + acc_t'(dig);
    mag_d = mag_q;
    ovf_d = ovf_q;
    if (acc_en && !ovf_q && dig < radix) begin
      if (sum[ACC_W-1:VALUE_BITS] != '0) begin
        ovf_d = 1'b1;
      end else begin
        mag_d = sum[VALUE_BITS-1:0];
      end
    end
  end

  always_comb begin
    done  = 1'b0;
    cnt_d = cnt_q;
    if (item_i.end_of_input || cnt_q >= limit) begin
      done = 1'b1;
    end else if (took) begin
      cnt_d = cnt_q + cnt_t'(1);
      done  = (cnt_d >= limit);
    end else begin
      done = 1'b1;
    end
  end

  // final value from the state after this character
  always_comb begin
    logic eff_took;
    logic eff_neg;
    logic eff_ovf;
    val_t eff_mag;
    eff_took = took && !item_i.end_of_input && (cnt_q < limit);
    eff_neg  = eff_took ? neg_d : neg_q;
    eff_ovf  = eff_took ? ovf_d : ovf_q;
    eff_mag  = eff_took ? mag_d : mag_q;
    sat      = 1'b0;
    if (cfg_i.signed_mode) begin
      if (eff_neg) begin
        if (eff_ovf || (eff_mag[VALUE_BITS-1] && eff_mag[VALUE_BITS-2:0] != '0)) begin
          sat  = 1'b1;
          fval = {1'b1, {(VALUE_BITS-1){1'b0}}};
        end else begin
          fval = val_t'(0) - eff_mag;
        end
      end else if (eff_ovf || eff_mag[VALUE_BITS-1]) begin
        sat  = 1'b1;
        fval = {1'b0, {(VALUE_BITS-1){1'b1}}};
      end else begin
        fval = eff_mag;
      end
    end else if (eff_ovf) begin
      sat  = 1'b1;
      fval = '1;
    end else begin
      fval = eff_neg ? (val_t'(0) - eff_mag) : eff_mag;
    end
  end

  assign new_base = rst_req_i.restart ? rst_req_i.base : cfg_i.base_mode;

  always_comb begin
    unique case (new_base)
      BASE_AUTO: ph_start = PH_AUTO_START;
      BASE_HEX:  ph_start = PH_HEX_START;
      default:   ph_start = PH_PLAIN_START;
    endcase
  end

  always_comb begin
    res_o.consumed   = took && !item_i.end_of_input && (cnt_q < limit);
    res_o.done_res   = done;
    res_o.value      = done ? fval : '0;
    res_o.char_count = cnt_d;
    res_o.saturated  = done && sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_PLAIN_START;
      base_q <= BASE_DEC;
      neg_q  <= 1'b0;
      mag_q  <= '0;
      ovf_q  <= 1'b0;
      cnt_q  <= '0;
    end else if ((rst_req_i.restart && cnt_q == '0) || (step_i && done)) begin
      ph_q   <= ph_start;
      base_q <= new_base;
      neg_q  <= 1'b0;
      mag_q  <= '0;
      ovf_q  <= 1'b0;
      cnt_q  <= '0;
    end else if (step_i && took) begin
      ph_q   <= ph_d;
      base_q <= base_d;
      neg_q  <= neg_d;
      mag_q  <= mag_d;
      ovf_q  <= ovf_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### sv/integer_text_scanner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// integer_text_scanner: streaming integer field scanner
// Scans signed or unsigned integers in octal, decimal, hex or auto base
// from a character stream, one result item per character item.
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// in        input      in_valid_i/in_ready_o  its_in_t  (char_code, end_of_input)
// out       output     out_valid_o/out_ready_i its_out_t (consumed .. saturated)
// cfg       input      APB psel/penable       base_mode, signed_mode, field_width
//
// One item per cycle sustained while the output is not stalled.
// Input register, combinational scan logic, result register.
// Output stall holds the input register; the input takes a new item
// whenever the input register is empty or moving forward.
// Reset restores decimal, signed, width 128 and an empty field.
// ----------------------------------------------------------------------------
module integer_text_scanner import its_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire its_in_t            in_data_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      its_out_t           out_data_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output      logic [PDATA_W-1:0] prdata,
  output      logic               pready
);

  its_cfg_t cfg;
  its_rst_t rst_req;
  its_out_t res;

  logic     in_vld_q;
  its_in_t  in_q;
  logic     out_vld_q;
  its_out_t out_q;
  logic     adv;

  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  its_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .rst_req_o (rst_req)
  );

  its_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (adv),
    .item_i    (in_q),
    .cfg_i     (cfg),
    .rst_req_i (rst_req),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_q <= in_data_i;
    if (adv) out_q <= res;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
